/* src/crse_pkg.sv */
`timescale 1ns / 1ps
// Package of types and constants shared by the Catmull-Rom spline evaluator.
package crse_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W = $clog2(MAX_POINTS);

	localparam int COORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int CNT_W = 7;
	localparam int PIDX_W = 6;
	localparam int COUNT_RESET = 4;

	localparam int SHIFT = FRAC_W + 1;
	localparam int DIFF_W = COORD_W + 4;
	localparam int PROD_W = DIFF_W + FRAC_W + 1;
	localparam int SUM_W = COORD_W + FRAC_W + 8;
	localparam int Q_W = SUM_W - SHIFT;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic op;
		logic [PIDX_W-1:0] point_index;
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
		logic [FRAC_W-1:0] param_t;
		logic param_end;
	} cmd_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
	} result_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		logic is_eval;
		logic wr_en;
		idx_t wr_idx;
		point_t wr_pt;
		idx_t idx0;
		idx_t idx1;
		idx_t idx2;
		idx_t idx3;
		frac_t frac;
	} job_t;

	typedef struct packed {
		coord_t p0;
		coord_t p1;
		coord_t p2;
		coord_t p3;
	} quad_t;

	typedef struct packed {
		quad_t x;
		quad_t y;
		quad_t z;
		frac_t f;
		frac_t f2;
		frac_t f3;
	} bundle_t;

endpackage

/* src/crse_front.sv */
`timescale 1ns / 1ps
// Front end: point count register, item classification, segment selection and job queue.
module crse_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  crse_pkg::cmd_t              cmd,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [crse_pkg::CNT_W-1:0]  cfg_data,
	output logic                        job_valid,
	output crse_pkg::job_t              job,
	input  logic                        job_pop
);
	import crse_pkg::*;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	logic [CNT_W-1:0] point_count_q;
	logic [31:0] count_w;
	idx_t last_idx;
	idx_t seg;
	logic [FRAC_W:0] t_val;
	logic [IDX_W+FRAC_W:0] prod;
	logic [IDX_W:0] seg_p2;
	job_t job_in;

	job_t q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] level_q;
	logic push_ok;
	logic pop_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(COUNT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			point_count_q <= cfg_data;
		end
	end

	// A count of zero acts as one, a count beyond the store acts as the store size.
	assign count_w = 32'(point_count_q);
	always_comb begin
		if (count_w == 32'd0) begin
			last_idx = '0;
		end else if (count_w > 32'(MAX_POINTS)) begin
			last_idx = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_idx = IDX_W'(count_w - 32'd1);
		end
	end

	assign t_val = cmd.param_end ? {1'b1, {FRAC_W{1'b0}}} : {1'b0, cmd.param_t};
	assign prod = {{IDX_W{1'b0}}, t_val} * {{(FRAC_W+1){1'b0}}, last_idx};
	assign seg = prod[IDX_W+FRAC_W-1:FRAC_W];
	assign seg_p2 = {1'b0, seg} + (IDX_W+1)'(2);

	always_comb begin
		job_in.is_eval = (cmd.op == OP_EVAL);
		job_in.wr_en = 32'(cmd.point_index) < 32'(MAX_POINTS);
		job_in.wr_idx = IDX_W'(32'(cmd.point_index));
		job_in.wr_pt = '{cmd.coord_x, cmd.coord_y, cmd.coord_z};
		job_in.idx0 = (seg != '0) ? seg - idx_t'(1) : '0;
		job_in.idx1 = seg;
		job_in.idx2 = (seg < last_idx) ? seg + idx_t'(1) : last_idx;
		job_in.idx3 = (seg_p2 <= {1'b0, last_idx}) ? seg_p2[IDX_W-1:0] : last_idx;
		job_in.frac = prod[FRAC_W-1:0];
	end

	assign full = (level_q == (QPTR_W+1)'(QDEPTH));
	assign job_valid = (level_q != '0);
	assign job = q_mem_q[rd_ptr_q];
	assign push_ok = push && !full;
	assign pop_ok = job_pop && job_valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				level_q <= level_q + (QPTR_W+1)'(1);
			end else if (!push_ok && pop_ok) begin
				level_q <= level_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

/* src/crse_fetch.sv */
`timescale 1ns / 1ps
// Back end sequencer: point memory, load writes and the four neighbour reads of an evaluation.
module crse_fetch (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  crse_pkg::job_t       job,
	output logic                 job_pop,
	output logic                 bundle_valid,
	output crse_pkg::bundle_t    bundle,
	input  logic                 bundle_ready
);
	import crse_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] cnt_q;
	logic take;
	logic start_eval;
	logic mem_we;
	logic rd_en;
	idx_t rd_addr;

	point_t pts_mem [MAX_POINTS];
	point_t rd_q;
	point_t p0_q;
	point_t p1_q;
	point_t p2_q;
	idx_t idx1_q;
	idx_t idx2_q;
	idx_t idx3_q;
	frac_t f_q;
	frac_t f2_q;
	frac_t f3_q;
	logic [2*FRAC_W-1:0] sq;
	logic [2*FRAC_W-1:0] cu;

	assign take = (state_q == ST_IDLE) || ((state_q == ST_LAST) && bundle_ready);
	assign job_pop = take && job_valid;
	assign start_eval = job_pop && job.is_eval;
	assign mem_we = job_pop && !job.is_eval && job.wr_en;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = job.idx0;
		if (start_eval) begin
			rd_en = 1'b1;
		end else if (state_q == ST_READ) begin
			rd_en = 1'b1;
			unique case (cnt_q)
				2'd1: rd_addr = idx1_q;
				2'd2: rd_addr = idx2_q;
				default: rd_addr = idx3_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pts_mem[job.wr_idx] <= job.wr_pt;
		end
		if (rd_en) begin
			rd_q <= pts_mem[rd_addr];
		end
	end

	assign sq = f_q * f_q;
	assign cu = f2_q * f_q;

	always_ff @(posedge clk) begin
		if (start_eval) begin
			idx1_q <= job.idx1;
			idx2_q <= job.idx2;
			idx3_q <= job.idx3;
			f_q <= job.frac;
		end
		if (state_q == ST_READ) begin
			unique case (cnt_q)
				2'd1: begin
					p0_q <= rd_q;
					f2_q <= sq[2*FRAC_W-1:FRAC_W];
				end
				2'd2: begin
					p1_q <= rd_q;
					f3_q <= cu[2*FRAC_W-1:FRAC_W];
				end
				default: p2_q <= rd_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q) inside
				ST_IDLE, ST_LAST: begin
					if (take) begin
						if (start_eval) begin
							state_q <= ST_READ;
							cnt_q <= 2'd1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					if (cnt_q == 2'd3) begin
						state_q <= ST_LAST;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The fourth point is still in the read register while the bundle is offered.
	assign bundle_valid = (state_q == ST_LAST);
	assign bundle = '{
		x:  '{p0_q.x, p1_q.x, p2_q.x, rd_q.x},
		y:  '{p0_q.y, p1_q.y, p2_q.y, rd_q.y},
		z:  '{p0_q.z, p1_q.z, p2_q.z, rd_q.z},
		f:  f_q,
		f2: f2_q,
		f3: f3_q
	};

endmodule

/* src/crse_arith.sv */
`timescale 1ns / 1ps
// Back end arithmetic: basis differences, products, sum, rounding, saturation and result register.
module crse_arith (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bundle_valid,
	input  crse_pkg::bundle_t    bundle,
	output logic                 bundle_ready,
	output logic                 empty,
	input  logic                 pop,
	output crse_pkg::result_t    result
);
	import crse_pkg::*;

	logic advance;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;
	frac_t f_s1;
	frac_t f2_s1;
	frac_t f3_s1;
	logic signed [FRAC_W:0] f_sx;
	logic signed [FRAC_W:0] f2_sx;
	logic signed [FRAC_W:0] f3_sx;
	quad_t quad [3];
	coord_t pos [3];
	result_t result_q;

	// The whole pipeline holds while a finished result waits to be taken.
	assign advance = !out_valid_q || pop;
	assign bundle_ready = advance;
	assign empty = !out_valid_q;
	assign result = result_q;

	assign quad[0] = bundle.x;
	assign quad[1] = bundle.y;
	assign quad[2] = bundle.z;

	assign f_sx = $signed({1'b0, f_s1});
	assign f2_sx = $signed({1'b0, f2_s1});
	assign f3_sx = $signed({1'b0, f3_s1});

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [DIFF_W-1:0] b_d;
		logic signed [DIFF_W-1:0] c_d;
		logic signed [DIFF_W-1:0] d_d;
		logic signed [DIFF_W-1:0] b_s1;
		logic signed [DIFF_W-1:0] c_s1;
		logic signed [DIFF_W-1:0] d_s1;
		coord_t p1_s1;
		coord_t p1_s2;
		logic signed [PROD_W-1:0] bf_s2;
		logic signed [PROD_W-1:0] cf_s2;
		logic signed [PROD_W-1:0] df_s2;
		logic signed [SUM_W-1:0] sum_s3;
		logic signed [Q_W-1:0] quo;
		logic signed [Q_W-1:0] quo_r;
		logic rnd;

		always_comb begin : p_diff
			logic signed [DIFF_W-1:0] e0;
			logic signed [DIFF_W-1:0] e1;
			logic signed [DIFF_W-1:0] e2;
			logic signed [DIFF_W-1:0] e3;
			logic signed [DIFF_W-1:0] m;
			e0 = DIFF_W'(quad[a].p0);
			e1 = DIFF_W'(quad[a].p1);
			e2 = DIFF_W'(quad[a].p2);
			e3 = DIFF_W'(quad[a].p3);
			m = e1 - e2;
			b_d = e2 - e0;
			c_d = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
			d_d = e3 - e0 + (m <<< 1) + m;
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				b_s1 <= b_d;
				c_s1 <= c_d;
				d_s1 <= d_d;
				p1_s1 <= quad[a].p1;
				bf_s2 <= b_s1 * f_sx;
				cf_s2 <= c_s1 * f2_sx;
				df_s2 <= d_s1 * f3_sx;
				p1_s2 <= p1_s1;
				sum_s3 <= (SUM_W'(p1_s2) <<< SHIFT) + SUM_W'(bf_s2) + SUM_W'(cf_s2)
					+ SUM_W'(df_s2);
			end
		end

		// Division by two to the seventeenth, truncated towards zero.
		assign quo = Q_W'(sum_s3 >>> SHIFT);
		assign rnd = sum_s3[SUM_W-1] && (sum_s3[SHIFT-1:0] != '0);
		assign quo_r = quo + Q_W'(rnd);
		assign pos[a] = ((quo_r[Q_W-1:COORD_W-1] == '0) || (quo_r[Q_W-1:COORD_W-1] == '1))
			? quo_r[COORD_W-1:0] : (quo_r[Q_W-1] ? COORD_MIN : COORD_MAX);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			f_s1 <= bundle.f;
			f2_s1 <= bundle.f2;
			f3_s1 <= bundle.f3;
			if (valid_s3) begin
				result_q <= '{pos[0], pos[1], pos[2]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= bundle_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

endmodule

/* src/catmull_rom_spline_eval_core.sv */
`timescale 1ns / 1ps
// Top level of the uniform Catmull-Rom spline evaluator over stored 3D control points.
//
//   Channel   Handshake            Accepted when          Payload
//   cmd       push / full          push && !full          cmd_t: op, index, point, t
//   result    empty / pop          pop && !empty          result_t: pos_x, pos_y, pos_z
//   cfg       cfg_valid/cfg_ready  cfg_valid && ready     point_count, 7 bits
//
// A load item gives no result.
// An evaluate item holds the back end for the four reads of the single-port point memory;
// its result then passes the arithmetic stages into the output register.
// Reset clears the job queue, the pipeline and sets point_count to 4; the point memory keeps
// its contents and an entry reads as undefined until it is written.
// A result waiting in the output register holds the arithmetic stages; the two-entry job
// queue keeps taking items until it fills, and full then stays high.
module catmull_rom_spline_eval_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  crse_pkg::cmd_t              cmd,
	output logic                        empty,
	input  logic                        pop,
	output crse_pkg::result_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [crse_pkg::CNT_W-1:0]  cfg_data
);
	import crse_pkg::*;

	logic job_valid;
	job_t job;
	logic job_pop;
	logic bundle_valid;
	bundle_t bundle;
	logic bundle_ready;

	crse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	crse_fetch u_fetch (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.bundle_ready (bundle_ready)
	);

	crse_arith u_arith (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.bundle_ready (bundle_ready),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule

/* src/crse_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the spline evaluator and its bind to the top level.
module crse_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input crse_pkg::cmd_t       cmd,
	input logic                 empty,
	input logic                 pop,
	input crse_pkg::result_t    result
);
	import crse_pkg::*;

	logic [7:0] pend_q;
	logic eval_in;
	logic res_out;

	assign eval_in = push && !full && (cmd.op == OP_EVAL);
	assign res_out = pop && !empty;

	// Evaluate items accepted whose results have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(eval_in) - 8'(res_out);
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result withdrawn");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("waiting result changed");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 8'd0)
		else $error("result shown with no evaluate item outstanding");

	a_no_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 8'd0 |=> empty)
		else $error("result appeared one cycle after acceptance");

endmodule

bind catmull_rom_spline_eval_core crse_checker u_crse_checker (.*);
